FILE: rtl/cfe_pkg.sv
`timescale 1ns / 1ps

package cfe_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic       REG_MAX_MOVES   = 1'b0;
  localparam logic [3:0] MAX_MOVES_RESET = 4'd8;

  localparam logic [15:0] HASH_SEED = 16'd5381;

  typedef enum logic [1:0] {
    K_INS,
    K_LOOK,
    K_CLR,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] key;
    logic        victim_pick;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] moves;
  } out_t;

  typedef struct packed {
    kind_t       kind;
    logic        pick;
    logic [15:0] fp;
  } cmd_t;

  // djb over low byte then high byte, kept to 16 bits
  function automatic logic [15:0] hash16(input logic [15:0] v);
    logic [15:0] h;
    h = HASH_SEED;
    h = (h << 5) + h + {8'h00, v[7:0]};
    h = (h << 5) + h + {8'h00, v[15:8]};
    return h;
  endfunction

endpackage

FILE: rtl/cuckoo_filter_engine.sv
`timescale 1ns / 1ps

// channel | signals                         | direction | word
// req     | req_valid, req_ready, req       | in        | opcode, key, victim_pick
// rsp     | rsp_valid, rsp_ready, rsp       | out       | ok, moves
// apb     | psel, penable, pwrite, paddr... | in        | max_moves at byte 0
//
// Insert relocates at most max_moves victims (one when max_moves is 0), each step
// being one table read then one write on the single RAM.
// Clear zeroes one table entry per cycle.
// A front register and the queue lie ahead of the back end.
// After reset the table is swept with req_ready low.
// A two-word queue lets req accept words while the back end works or rsp stalls.
module cuckoo_filter_engine #(
  parameter int BUCKETS = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cfe_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cfe_pkg::out_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  import cfe_pkg::*;

  logic [3:0] max_moves;
  logic       init_busy;
  logic       f_valid;
  logic       f_ready;
  cmd_t       f_cmd;
  logic       q_valid;
  logic       q_ready;
  cmd_t       q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_MOVES) ? {28'h0, max_moves} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_moves <= MAX_MOVES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_MOVES)) begin
      max_moves <= pwdata[3:0];
    end
  end

  cfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  cfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .w_valid (f_valid),
    .w_ready (f_ready),
    .w_cmd   (f_cmd),
    .r_valid (q_valid),
    .r_ready (q_ready),
    .r_cmd   (q_cmd)
  );

  cfe_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_moves (max_moves),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/cfe_ram.sv
`timescale 1ns / 1ps

module cfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cfe_front.sv
`timescale 1ns / 1ps

module cfe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          req_valid,
  output logic          req_ready,
  input  cfe_pkg::in_t  req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cfe_pkg::cmd_t cmd
);

  import cfe_pkg::*;

  logic  s_valid;
  cmd_t  s_cmd;
  kind_t kind;

  always_comb begin
    case (req.opcode)
      OP_INSERT: kind = K_INS;
      OP_LOOKUP: kind = K_LOOK;
      OP_CLEAR:  kind = K_CLR;
      default:   kind = K_NOP;
    endcase
  end

  assign req_ready = !hold && (!s_valid || cmd_ready);
  assign cmd_valid = s_valid;
  assign cmd       = s_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s_valid    <= 1'b1;
      s_cmd.kind <= kind;
      s_cmd.pick <= req.victim_pick;
      s_cmd.fp   <= hash16(req.key);
    end else if (cmd_ready) begin
      s_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/cfe_queue.sv
`timescale 1ns / 1ps

module cfe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          w_valid,
  output logic          w_ready,
  input  cfe_pkg::cmd_t w_cmd,
  output logic          r_valid,
  input  logic          r_ready,
  output cfe_pkg::cmd_t r_cmd
);

  import cfe_pkg::*;

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign w_ready = (cnt != 2'd2);
  assign r_valid = (cnt != 2'd0);
  assign r_cmd   = slots[rp];
  assign push    = w_valid && w_ready;
  assign pop     = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= w_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/cfe_back.sv
`timescale 1ns / 1ps

module cfe_back #(
  parameter int BUCKETS = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    max_moves,
  output logic          init_busy,
  input  logic          q_valid,
  output logic          q_ready,
  input  cfe_pkg::cmd_t q_cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cfe_pkg::out_t rsp
);

  import cfe_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam logic [IW-1:0] LAST = IW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_RD2,
    S_CHK,
    S_MOVE_A,
    S_MOVE_B,
    S_DONE
  } state_t;

  state_t      state;
  logic [IW-1:0] cnt;
  logic        report;
  kind_t       kind;
  logic        pick;
  logic [15:0] fp;
  logic [IW-1:0] i1;
  logic [IW-1:0] i2;
  logic [15:0] d1;
  logic [IW-1:0] vi;
  logic [15:0] victim;
  logic [3:0]  moves;
  logic        res_ok;

  logic [3:0]    lim;
  logic [3:0]    moves_next;
  logic [15:0]   hf;
  logic [15:0]   hv;
  logic [IW-1:0] nvi;
  logic          res_load;

  logic          we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;
  logic [IW-1:0] raddr;
  logic [15:0]   rd;

  cfe_ram #(
    .WIDTH (16),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  assign lim        = (max_moves == 4'd0) ? 4'd1 : max_moves;
  assign moves_next = moves + 4'd1;
  assign hf         = hash16(fp);
  assign hv         = hash16(victim);
  assign nvi        = vi ^ hv[IW-1:0];
  assign q_ready    = (state == S_IDLE);
  assign init_busy  = (state == S_CLR) && !report;
  assign res_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 16'h0000;
    raddr = i1;
    case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_RD2: begin
        raddr = i2;
      end
      S_CHK: begin
        if (kind == K_INS) begin
          we    = 1'b1;
          wdata = fp;
          if (d1 == 16'h0000) begin
            waddr = i1;
          end else if (rd == 16'h0000) begin
            waddr = i2;
          end else begin
            waddr = pick ? i1 : i2;
          end
        end
      end
      S_MOVE_A: begin
        raddr = nvi;
      end
      S_MOVE_B: begin
        we    = 1'b1;
        waddr = vi;
        wdata = victim;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      report    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !res_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + IW'(1);
          if (cnt == LAST) begin
            state <= report ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            kind   <= q_cmd.kind;
            pick   <= q_cmd.pick;
            fp     <= q_cmd.fp;
            i1     <= q_cmd.fp[IW-1:0];
            moves  <= 4'd0;
            res_ok <= 1'b0;
            case (q_cmd.kind)
              K_CLR: begin
                report <= 1'b1;
                cnt    <= '0;
                res_ok <= 1'b1;
                state  <= S_CLR;
              end
              K_NOP: begin
                state <= S_DONE;
              end
              default: begin
                state <= S_HASH;
              end
            endcase
          end
        end
        S_HASH: begin
          i2    <= i1 ^ hf[IW-1:0];
          state <= S_RD2;
        end
        S_RD2: begin
          d1    <= rd;
          state <= S_CHK;
        end
        S_CHK: begin
          if (kind == K_LOOK) begin
            res_ok <= (d1 == fp) || (rd == fp);
            state  <= S_DONE;
          end else if ((d1 == 16'h0000) || (rd == 16'h0000)) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else begin
            vi     <= pick ? i1 : i2;
            victim <= pick ? d1 : rd;
            state  <= S_MOVE_A;
          end
        end
        S_MOVE_A: begin
          vi    <= nvi;
          state <= S_MOVE_B;
        end
        S_MOVE_B: begin
          victim <= rd;
          moves  <= moves_next;
          if (rd == 16'h0000) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else if (moves_next >= lim) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else begin
            state <= S_MOVE_A;
          end
        end
        S_DONE: begin
          if (res_load) begin
            rsp_valid <= 1'b1;
            rsp.ok    <= res_ok;
            rsp.moves <= moves;
            report    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_reset_sweep: assert property (@(posedge clk) rst |=> (state == S_CLR) && init_busy)
    else $error("reset did not start the table sweep");

  a_victim_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_B) |-> (victim != 16'h0000))
    else $error("relocating an empty victim");

  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_A) |-> (moves < lim))
    else $error("relocation past the move limit");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (moves <= lim))
    else $error("reported move count above limit");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import cfe_pkg::*;

  localparam int BUCKETS = 128;
  localparam int IDX_W = $clog2(BUCKETS);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_MAX_MOVES = {REG_MAX_MOVES, 2'b00};
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 7;
  localparam int WORDS_PER_PHASE = 100;

  typedef struct packed {
    logic drain;
    in_t  word;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  in_t         req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  out_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] shadow [BUCKETS];
  logic [3:0]  move_limit;

  pending_t    pending_req [$];
  out_t        expected_rsp [$];
  logic [15:0] stored_keys [$];
  logic [15:0] collide_keys [$];
  logic [15:0] zero_fp_keys [$];

  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  pattern_age = '0;
  int          stall_cycles = 0;
  int          fail_count = 0;
  out_t        want;

  cuckoo_filter_engine #(.BUCKETS(BUCKETS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [15:0] djb16(input logic [15:0] v);
    logic [31:0] h;
    h = {16'd0, HASH_SEED};
    h = h * 33 + v[7:0];
    h = h * 33 + v[15:8];
    return h[15:0];
  endfunction

  function automatic out_t filter_apply(input in_t w);
    out_t             r;
    logic [15:0]      fp, victim, nxt, vh;
    logic [IDX_W-1:0] i1, i2, vi;
    int               lim, steps, b;
    r = '0;
    fp = djb16(w.key);
    vh = djb16(fp);
    i1 = fp[IDX_W-1:0];
    i2 = i1 ^ vh[IDX_W-1:0];
    case (w.opcode)
      OP_CLEAR: begin
        for (b = 0; b < BUCKETS; b++) shadow[b] = '0;
        r.ok = 1'b1;
      end
      OP_LOOKUP: r.ok = (shadow[i1] == fp) || (shadow[i2] == fp);
      OP_INSERT: begin
        if (shadow[i1] == 16'd0) begin
          shadow[i1] = fp;
          r.ok = 1'b1;
        end else if (shadow[i2] == 16'd0) begin
          shadow[i2] = fp;
          r.ok = 1'b1;
        end else begin
          lim = (move_limit == 4'd0) ? 1 : int'(move_limit);
          vi = w.victim_pick ? i1 : i2;
          victim = shadow[vi];
          shadow[vi] = fp;
          steps = 0;
          while (steps == 0 || (victim != 16'd0 && steps < lim)) begin
            vh = djb16(victim);
            vi = vi ^ vh[IDX_W-1:0];
            nxt = shadow[vi];
            shadow[vi] = victim;
            victim = nxt;
            steps++;
          end
          r.ok = (victim == 16'd0);
          r.moves = steps[3:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: bursts of words with random gaps while send_idle is set
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) expected_rsp.push_back(filter_apply(req));
      if (!(req_valid && !req_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_req.size() != 0 &&
                     (!pending_req[0].drain || expected_rsp.size() == 0)) begin
          req <= pending_req[0].word;
          req_valid <= 1'b1;
          void'(pending_req.pop_front());
          if (send_idle) begin
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 24);
              gap_left = $urandom_range(1, 12);
            end else begin
              burst_left--;
            end
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating ready pattern, reloaded now and then; ready held high while recv_idle is clear
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (pattern_age == 6'd63) begin
        if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
        else ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      pattern_age <= pattern_age + 6'd1;
      rsp_ready <= ready_pattern[0] || !recv_idle;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response word: ok=%0d moves=%0d", rsp.ok, rsp.moves);
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
          fail_count++;
        end
        if (rsp.moves !== want.moves) begin
          $error("moves: expected %0d, actual %0d", want.moves, rsp.moves);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("cuckoo_filter_engine test failed");
        $finish;
      end
    end
  end

  task automatic write_max_moves(input logic [3:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_MOVES;
    pwdata <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    move_limit = v;
  endtask

  task automatic queue_word(input logic [1:0] op, input logic [15:0] key, input logic pick,
                            input logic drain);
    pending_t p;
    p.drain = drain;
    p.word.opcode = op;
    p.word.key = key;
    p.word.victim_pick = pick;
    pending_req.push_back(p);
    if (op == OP_INSERT) begin
      stored_keys.push_back(key);
      if (stored_keys.size() > 64) void'(stored_keys.pop_front());
    end
  endtask

  task automatic wait_drained();
    while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_phase(input int count, input logic first_drain);
    int          n, r;
    logic [15:0] key;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_word(OP_CLEAR, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                   1'b0);
      end else if (r < 5) begin
        queue_word(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                   1'b0);
      end else if (r < 55) begin
        if ($urandom_range(0, 4) == 0) key = collide_keys[$urandom_range(0, 5)];
        else key = 16'($urandom_range(0, 16'hFFFF));
        queue_word(OP_INSERT, key, 1'($urandom_range(0, 1)),
                   (n == 0 && first_drain) || $urandom_range(0, 59) == 0);
      end else begin
        if (stored_keys.size() != 0 && $urandom_range(0, 1) == 1)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else
          key = 16'($urandom_range(0, 16'hFFFF));
        queue_word(OP_LOOKUP, key, 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  initial begin
    int          k, p;
    logic [15:0] h, target;
    logic [3:0]  limits [RANDOM_PHASES];
    for (k = 0; k < BUCKETS; k++) shadow[k] = '0;
    move_limit = MAX_MOVES_RESET;
    target = djb16(16'h0000);
    for (k = 0; k < 65536; k++) begin
      h = djb16(k[15:0]);
      if (h == 16'd0) zero_fp_keys.push_back(k[15:0]);
      if (h[IDX_W-1:0] == target[IDX_W-1:0] && collide_keys.size() < 6)
        collide_keys.push_back(k[15:0]);
    end

    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_word(OP_INSERT, 16'h0000, 1'b0, 1'b0);
    queue_word(OP_INSERT, 16'hFFFF, 1'b1, 1'b0);
    queue_word(OP_LOOKUP, 16'h0000, 1'b0, 1'b0);
    queue_word(OP_LOOKUP, 16'hFFFF, 1'b1, 1'b0);
    queue_word(OP_LOOKUP, 16'h5A5A, 1'b0, 1'b0);
    queue_word(OP_UNUSED, 16'hFFFF, 1'b1, 1'b0);
    queue_word(OP_LOOKUP, 16'hFFFF, 1'b0, 1'b0);
    queue_word(OP_CLEAR, 16'h0000, 1'b0, 1'b0);
    queue_word(OP_LOOKUP, 16'h0000, 1'b0, 1'b0);
    for (k = 0; k < collide_keys.size(); k++) queue_word(OP_INSERT, collide_keys[k], k[0], 1'b0);
    for (k = 0; k < collide_keys.size(); k++) queue_word(OP_LOOKUP, collide_keys[k], 1'b0, 1'b0);
    if (zero_fp_keys.size() != 0) begin
      queue_word(OP_INSERT, zero_fp_keys[0], 1'b1, 1'b0);
      queue_word(OP_LOOKUP, zero_fp_keys[0], 1'b0, 1'b0);
    end
    wait_drained();

    limits[0] = 4'd1;
    limits[1] = 4'd0;
    limits[2] = 4'd15;
    limits[3] = 4'd8;
    for (p = 4; p < RANDOM_PHASES; p++) limits[p] = 4'($urandom_range(0, 15));
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_max_moves(limits[p]);
      send_idle = (p % 3 != 1);
      recv_idle = (p % 3 != 2);
      queue_random_phase(WORDS_PER_PHASE, p == 0);
      wait_drained();
    end

    if (expected_rsp.size() != 0) begin
      $error("%0d response words never arrived", expected_rsp.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("cuckoo_filter_engine test passed");
    end else begin
      $display("cuckoo_filter_engine test failed");
    end
    $finish;
  end

endmodule

FILE: cuckoo_filter_engine.f
rtl/cfe_pkg.sv
rtl/cfe_ram.sv
rtl/cfe_front.sv
rtl/cfe_queue.sv
rtl/cfe_back.sv
rtl/cuckoo_filter_engine.sv
bench/tb.sv
